FILE: rtl/smm_pkg.sv
// smm_pkg: command codes, error codes and field widths of the segmented memory manager.
// No dependencies; imported by smm_word_ram and segmented_memory_manager.

package smm_pkg;

    localparam int CMD_W      = 3;
    localparam int ID_FIELD_W = 6;
    localparam int OFF_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int LEN_W      = 11;
    localparam int WORD_W     = 32;
    localparam int ERR_W      = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_MAP    = 3'd0,
        CMD_UNMAP  = 3'd1,
        CMD_READ   = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_REMOVE = 3'd4,
        CMD_COPY   = 3'd5,
        CMD_LENGTH = 3'd6
    } cmd_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK      = 3'd0,
        ERR_NO_ID   = 3'd1,
        ERR_BAD_SEG = 3'd2,
        ERR_OFFSET  = 3'd3,
        ERR_SIZE    = 3'd4
    } err_t;

endpackage

FILE: rtl/smm_word_ram.sv
// smm_word_ram: single-port word store with registered read data.
// Depends on smm_pkg for the word width.

module smm_word_ram #(
    parameter longint unsigned DEPTH = 65536,
    parameter int              AW    = 16
) (
    input  logic                      clk,
    input  logic [AW-1:0]             addr,
    input  logic                      wr_en,
    input  logic [smm_pkg::WORD_W-1:0] wr_data,
    output logic [smm_pkg::WORD_W-1:0] rd_data
);
    import smm_pkg::*;

    logic [WORD_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        rd_data <= mem[addr];
    end

endmodule

FILE: rtl/segmented_memory_manager.sv
// segmented_memory_manager: segment table, free-id stack and sequencer around one word store.
// Depends on smm_pkg and smm_word_ram.
//
// Usage: one command word enters on the input channel (in_valid / in_stall) and
// exactly one result word leaves on the output channel (out_valid / out_stall).
// A word moves at a clock edge with valid high and stall low.
// Commands run one at a time through a small sequencer that owns the single
// port of the word store; in_stall is high from acceptance until the result is
// placed in the output register.
// Steps after acceptance: every command passes a lookup state (S_LOOK) and a
// done state (S_DONE); unmap, write, length and errors go straight from one to
// the other, read and remove add a word access (S_WORD), map writes one zero
// word per cycle in S_FILL for each word of its size, and copy reads then
// writes each source word in turn (S_CRD, S_CWR).
// The next command is taken in the cycle after a result is loaded, so
// commands never overlap.
// While the receiver stalls, the result is held in the output register; a
// following command may be accepted and run, and waits before loading its result.
// Reset clears the mapped flags, the free count, the fresh-id counter and the
// output valid; stored words, lengths and stack entries are undefined until written.

module segmented_memory_manager #(
    parameter int MAX_SEGMENTS  = 64,
    parameter int SEGMENT_WORDS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [smm_pkg::CMD_W-1:0]      cmd,
    input  logic [smm_pkg::ID_FIELD_W-1:0] seg_id,
    input  logic [smm_pkg::ID_FIELD_W-1:0] dest_id,
    input  logic [smm_pkg::OFF_W-1:0]      word_offset,
    input  logic [smm_pkg::SIZE_W-1:0]     new_size,
    input  logic [smm_pkg::WORD_W-1:0]     write_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [smm_pkg::WORD_W-1:0]     read_value,
    output logic [smm_pkg::ID_FIELD_W-1:0] new_id,
    output logic [smm_pkg::LEN_W-1:0]      seg_length,
    output logic [smm_pkg::ERR_W-1:0]      error
);
    import smm_pkg::*;

    localparam longint unsigned TOTAL_WORDS = longint'(MAX_SEGMENTS) * longint'(SEGMENT_WORDS);
    localparam int AW   = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
    localparam int ID_W = $clog2(MAX_SEGMENTS);
    localparam int FC_W = ID_W + 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LOOK = 7'b0000010,
        S_WORD = 7'b0000100,
        S_FILL = 7'b0001000,
        S_CRD  = 7'b0010000,
        S_CWR  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    function automatic logic [ID_W-1:0] to_idx(input logic [ID_FIELD_W-1:0] id);
        return ID_W'(id);
    endfunction

    state_t state_reg, state_next;

    logic [CMD_W-1:0]      cmd_reg;
    logic [ID_FIELD_W-1:0] sid_reg;
    logic [ID_FIELD_W-1:0] did_reg;
    logic [OFF_W-1:0]      off_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [WORD_W-1:0]     val_reg;
    logic [AW-1:0]         src_base_reg;
    logic [AW-1:0]         dst_base_reg;
    logic [LEN_W-1:0]      cnt_reg;
    logic [LEN_W-1:0]      limit_reg;

    logic [MAX_SEGMENTS-1:0] mapped_reg;
    logic [FC_W-1:0]         free_cnt_reg;
    logic [FC_W-1:0]         fresh_reg;

    logic [LEN_W-1:0] len_mem [0:MAX_SEGMENTS-1];
    logic [ID_W-1:0]  stack_mem [0:MAX_SEGMENTS-1];
    logic [LEN_W-1:0] len_q;
    logic [ID_W-1:0]  stack_q;

    logic [WORD_W-1:0]     res_rd_reg;
    logic [ID_FIELD_W-1:0] res_nid_reg;
    logic [LEN_W-1:0]      res_len_reg;
    logic [ERR_W-1:0]      res_err_reg;

    logic                  out_valid_reg;
    logic [WORD_W-1:0]     out_rd_reg;
    logic [ID_FIELD_W-1:0] out_nid_reg;
    logic [LEN_W-1:0]      out_len_reg;
    logic [ERR_W-1:0]      out_err_reg;

    logic in_acc;
    logic out_free;
    logic sid_ok;
    logic did_ok;
    logic off_bad;
    logic size_bad;
    logic [ID_W-1:0] map_id;
    logic            map_avail;
    logic            word_go;

    logic [AW-1:0]     ram_base;
    logic [LEN_W-1:0]  ram_off;
    logic [AW-1:0]     ram_addr;
    logic              ram_we;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    assign in_acc   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign sid_ok   = (32'(sid_reg) < 32'(MAX_SEGMENTS)) && mapped_reg[to_idx(sid_reg)];
    assign did_ok   = (32'(did_reg) < 32'(MAX_SEGMENTS)) && mapped_reg[to_idx(did_reg)];
    assign off_bad  = LEN_W'(off_reg) >= len_q;
    assign size_bad = 32'(size_reg) > 32'(SEGMENT_WORDS);
    assign word_go  = sid_ok && !off_bad;

    always_comb
    begin
        map_avail = 1'b1;
        if (free_cnt_reg != '0)
        begin
            map_id = stack_q;
        end
        else
        begin
            map_id    = ID_W'(fresh_reg);
            map_avail = fresh_reg < FC_W'(MAX_SEGMENTS);
        end
    end

    // word store port
    always_comb
    begin
        ram_base  = ((state_reg == S_FILL) || (state_reg == S_CWR)) ? dst_base_reg : src_base_reg;
        ram_off   = ((state_reg == S_LOOK) || (state_reg == S_WORD)) ? LEN_W'(off_reg) : cnt_reg;
        ram_addr  = ram_base + AW'(ram_off);
        ram_we    = 1'b0;
        ram_wdata = '0;
        unique case (state_reg)
            S_LOOK:
            begin
                ram_we    = (cmd_reg == CMD_WRITE) && word_go;
                ram_wdata = val_reg;
            end
            S_WORD:
            begin
                ram_we = (cmd_reg == CMD_REMOVE);
            end
            S_FILL:
            begin
                ram_we = 1'b1;
            end
            S_CWR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    smm_word_ram #(
        .DEPTH (TOTAL_WORDS),
        .AW    (AW)
    ) u_word_ram (
        .clk     (clk),
        .addr    (ram_addr),
        .wr_en   (ram_we),
        .wr_data (ram_wdata),
        .rd_data (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_DONE;
                case (cmd_reg)
                    CMD_MAP:
                    begin
                        if (!size_bad && map_avail && (size_reg != '0))
                        begin
                            state_next = S_FILL;
                        end
                    end
                    CMD_READ, CMD_REMOVE:
                    begin
                        if (word_go)
                        begin
                            state_next = S_WORD;
                        end
                    end
                    CMD_COPY:
                    begin
                        if ((sid_reg != did_reg) && sid_ok && did_ok && (len_q != '0))
                        begin
                            state_next = S_CRD;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_WORD:
            begin
                state_next = S_DONE;
            end
            S_FILL:
            begin
                if (LEN_W'(cnt_reg + 1'b1) == limit_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_CRD:
            begin
                state_next = S_CWR;
            end
            S_CWR:
            begin
                state_next = (LEN_W'(cnt_reg + 1'b1) == limit_reg) ? S_DONE : S_CRD;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mapped_reg    <= '0;
            free_cnt_reg  <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_LOOK)
            begin
                case (cmd_reg)
                    CMD_MAP:
                    begin
                        if (!size_bad && map_avail)
                        begin
                            mapped_reg[map_id] <= 1'b1;
                            if (free_cnt_reg != '0)
                            begin
                                free_cnt_reg <= free_cnt_reg - 1'b1;
                            end
                            else
                            begin
                                fresh_reg <= fresh_reg + 1'b1;
                            end
                        end
                    end
                    CMD_UNMAP:
                    begin
                        if ((sid_reg != '0) && sid_ok)
                        begin
                            mapped_reg[to_idx(sid_reg)] <= 1'b0;
                            if (free_cnt_reg < FC_W'(MAX_SEGMENTS))
                            begin
                                free_cnt_reg <= free_cnt_reg + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        free_cnt_reg <= free_cnt_reg;
                    end
                endcase
            end
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // table memories, command fields, counters and results
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg      <= cmd;
            sid_reg      <= seg_id;
            did_reg      <= dest_id;
            off_reg      <= word_offset;
            size_reg     <= new_size;
            val_reg      <= write_value;
            src_base_reg <= AW'(to_idx(seg_id)) * AW'(SEGMENT_WORDS);
            dst_base_reg <= AW'(to_idx(dest_id)) * AW'(SEGMENT_WORDS);
            len_q        <= len_mem[to_idx(seg_id)];
            stack_q      <= stack_mem[ID_W'(free_cnt_reg - 1'b1)];
        end

        if (state_reg == S_LOOK)
        begin
            res_rd_reg  <= '0;
            res_nid_reg <= '0;
            res_len_reg <= '0;
            res_err_reg <= ERR_OK;
            cnt_reg     <= '0;
            case (cmd_reg)
                CMD_MAP:
                begin
                    if (size_bad)
                    begin
                        res_err_reg <= ERR_SIZE;
                    end
                    else if (!map_avail)
                    begin
                        res_err_reg <= ERR_NO_ID;
                    end
                    else
                    begin
                        len_mem[map_id] <= LEN_W'(size_reg);
                        res_nid_reg     <= ID_FIELD_W'(map_id);
                        dst_base_reg    <= AW'(map_id) * AW'(SEGMENT_WORDS);
                        limit_reg       <= LEN_W'(size_reg);
                    end
                end
                CMD_UNMAP:
                begin
                    if (sid_reg != '0)
                    begin
                        if (!sid_ok)
                        begin
                            res_err_reg <= ERR_BAD_SEG;
                        end
                        else if (free_cnt_reg < FC_W'(MAX_SEGMENTS))
                        begin
                            stack_mem[ID_W'(free_cnt_reg)] <= to_idx(sid_reg);
                        end
                    end
                end
                CMD_READ, CMD_WRITE, CMD_REMOVE:
                begin
                    if (!sid_ok)
                    begin
                        res_err_reg <= ERR_BAD_SEG;
                    end
                    else if (off_bad)
                    begin
                        res_err_reg <= ERR_OFFSET;
                    end
                end
                CMD_COPY:
                begin
                    if (sid_reg != did_reg)
                    begin
                        if (!sid_ok || !did_ok)
                        begin
                            res_err_reg <= ERR_BAD_SEG;
                        end
                        else
                        begin
                            len_mem[to_idx(did_reg)] <= len_q;
                            limit_reg                <= len_q;
                        end
                    end
                end
                CMD_LENGTH:
                begin
                    if (!sid_ok)
                    begin
                        res_err_reg <= ERR_BAD_SEG;
                    end
                    else
                    begin
                        res_len_reg <= len_q;
                    end
                end
                default:
                begin
                    res_err_reg <= ERR_OK;
                end
            endcase
        end

        if (state_reg == S_WORD)
        begin
            res_rd_reg <= ram_rdata;
        end

        if ((state_reg == S_FILL) || (state_reg == S_CWR))
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end

        if ((state_reg == S_DONE) && out_free)
        begin
            out_rd_reg  <= res_rd_reg;
            out_nid_reg <= res_nid_reg;
            out_len_reg <= res_len_reg;
            out_err_reg <= res_err_reg;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign read_value = out_rd_reg;
    assign new_id     = out_nid_reg;
    assign seg_length = out_len_reg;
    assign error      = out_err_reg;

    a_free_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg <= FC_W'(MAX_SEGMENTS))
        else $error("free count above segment count");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= FC_W'(MAX_SEGMENTS))
        else $error("fresh id counter above segment count");

    a_err_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_err_reg != ERR_OK)) |->
        ((out_rd_reg == '0) && (out_nid_reg == '0) && (out_len_reg == '0)))
        else $error("error result carries nonzero fields");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside done state");

    a_fill_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> ((cmd_reg == CMD_MAP) && (cnt_reg < limit_reg)))
        else $error("zero fill outside map or past size");

endmodule
